// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mpv_pkg.sv
// ----------------------------------------------------------------------------
// mpv_pkg
// types, constants and register codes of the period-to-voltage block
// ----------------------------------------------------------------------------
package mpv_pkg;

  // field widths
  localparam int CHAN_W    = 3;
  localparam int TS_W      = 32;
  localparam int VOLT_W    = 31;
  localparam int COEFF_W   = 31;
  localparam int MAXP_W    = 32;

  // defaults for the top-level parameters
  localparam int CHANNELS_DEF  = 5;
  localparam int TIME_BITS_DEF = 32;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] NUM_COEFF_REGS = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MAX_PERIOD = 3'd5;

  // reset values
  localparam logic [COEFF_W-1:0] COEFF_RESET      = 31'd7692308;
  localparam logic [MAXP_W-1:0]  MAX_PERIOD_RESET = 32'd1000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } mpv_state_t;

  typedef struct packed {
    logic               start;
    logic [COEFF_W-1:0] dividend;
    logic [MAXP_W-1:0]  divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic               done;
    logic [COEFF_W-1:0] quotient;
  } div_stat_t;

endpackage

// File: hdl/mpv_if.sv
// ----------------------------------------------------------------------------
// mpv channel interfaces
// valid/ready channels for edge events and voltage results
// ----------------------------------------------------------------------------
interface mpv_in_if;
  logic                        valid;
  logic                        ready;
  logic [mpv_pkg::CHAN_W-1:0]  channel;
  logic [mpv_pkg::TS_W-1:0]    timestamp;

  modport source (output valid, output channel, output timestamp, input ready);
  modport sink   (input valid, input channel, input timestamp, output ready);
endinterface

interface mpv_out_if;
  logic                        valid;
  logic                        ready;
  logic [mpv_pkg::CHAN_W-1:0]  out_channel;
  logic [mpv_pkg::VOLT_W-1:0]  voltage;
  logic                        accepted;

  modport source (output valid, output out_channel, output voltage, output accepted,
                  input ready);
  modport sink   (input valid, input out_channel, input voltage, input accepted,
                  output ready);
endinterface

// File: hdl/multichannel_period_to_voltage.sv
// ----------------------------------------------------------------------------
// multichannel_period_to_voltage
// reciprocal frequency counter: per-channel edge period turned into a voltage
// ----------------------------------------------------------------------------
//
//  port group  dir   handshake            payload
//  in_evt      in    valid/ready          channel, timestamp
//  out_res     out   valid/ready          out_channel, voltage, accepted
//  cfg_*       in    apb, pready tied     coeff_0..4, max_period
//
//  an edge whose voltage is updated passes subtract, check, 31 divider steps,
//  write and load; a rejected edge passes subtract, check and load; one edge is
//  in work at a time, and the next edge is taken in the cycle after the load
//  the output register lets the result wait while the next edge is taken;
//  a stalled result holds only the final load
//  reset (synchronous, active low) clears channel times and voltages, and loads register defaults
//
module multichannel_period_to_voltage #(
  parameter int CHANNELS  = mpv_pkg::CHANNELS_DEF,
  parameter int TIME_BITS = mpv_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mpv_in_if.sink                          in_evt,
  mpv_out_if.source                       out_res,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mpv_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [mpv_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [mpv_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHX_W    = (CH_IDX_W > mpv_pkg::CHAN_W) ? CH_IDX_W : mpv_pkg::CHAN_W;
  localparam int PW       = mpv_pkg::MAXP_W;

  // fsm and edge context
  mpv_pkg::mpv_state_t state_r, state_nxt;
  logic [mpv_pkg::CHAN_W-1:0]  ch_r, ch_nxt;
  logic [TIME_BITS-1:0]        ts_r, ts_nxt;
  logic [TIME_BITS-1:0]        period_r, period_nxt;
  logic                        ok_r, ok_nxt;

  // per-channel state
  logic [TIME_BITS-1:0]        last_r [CHANNELS];
  logic [mpv_pkg::VOLT_W-1:0]  held_r [CHANNELS];

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [mpv_pkg::CHAN_W-1:0]  out_ch_r, out_ch_nxt;
  logic [mpv_pkg::VOLT_W-1:0]  out_volt_r, out_volt_nxt;
  logic                        out_acc_r, out_acc_nxt;

  logic [TIME_BITS-1:0]        ts_in;
  logic [CHX_W-1:0]            chx;
  logic [CH_IDX_W-1:0]         sel;
  logic                        in_range;
  logic [PW-1:0]               per_lo;
  logic                        per_hi;
  logic                        period_ok;
  logic                        in_xfer;
  logic                        slot_free;
  logic                        last_we;
  logic                        held_we;

  logic [mpv_pkg::COEFF_W-1:0] coeff_sel;
  logic [PW-1:0]               max_period;
  mpv_pkg::div_ctrl_t          div_ctrl;
  mpv_pkg::div_stat_t          div_stat;

  mpv_cfg #(
    .CHANNELS (CHANNELS),
    .CH_IDX_W (CH_IDX_W)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .sel        (sel),
    .coeff_sel  (coeff_sel),
    .max_period (max_period)
  );

  mpv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (div_ctrl),
    .stat  (div_stat)
  );

  assign cfg_pready = 1'b1;

  // timestamp taken modulo 2^TIME_BITS, zero-extended when the counter is wider
  always_comb begin
    for (int i = 0; i < TIME_BITS; i++) begin
      ts_in[i] = (i < mpv_pkg::TS_W) ? in_evt.timestamp[i % mpv_pkg::TS_W] : 1'b0;
    end
  end

  // channel decode; an out-of-range edge touches no per-channel state
  assign chx      = CHX_W'(ch_r);
  assign in_range = (32'(ch_r) < CHANNELS);
  assign sel      = in_range ? chx[CH_IDX_W-1:0] : '0;

  // split the period into the divisor word and an overflow flag
  always_comb begin
    per_lo = '0;
    per_hi = 1'b0;
    for (int i = 0; i < TIME_BITS; i++) begin
      if (i < PW) begin
        per_lo[i % PW] = period_r[i];
      end else begin
        per_hi = per_hi | period_r[i];
      end
    end
  end

  // zero period rejected here, so the divider never sees a zero divisor
  assign period_ok = in_range && !per_hi && (per_lo != '0) && (per_lo < max_period);

  assign in_evt.ready = (state_r == mpv_pkg::ST_IDLE);
  assign in_xfer      = in_evt.valid && in_evt.ready;
  assign slot_free    = !out_valid_r || out_res.ready;

  always_comb begin
    state_nxt         = state_r;
    ch_nxt            = ch_r;
    ts_nxt            = ts_r;
    period_nxt        = period_r;
    ok_nxt            = ok_r;
    out_valid_nxt     = out_valid_r && !out_res.ready;
    out_ch_nxt        = out_ch_r;
    out_volt_nxt      = out_volt_r;
    out_acc_nxt       = out_acc_r;
    last_we           = 1'b0;
    held_we           = 1'b0;
    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = coeff_sel;
    div_ctrl.divisor  = per_lo;

    unique case (state_r)
      mpv_pkg::ST_IDLE: begin
        if (in_xfer) begin
          ch_nxt    = in_evt.channel;
          ts_nxt    = ts_in;
          state_nxt = mpv_pkg::ST_CALC;
        end
      end
      mpv_pkg::ST_CALC: begin
        // period modulo 2^TIME_BITS; last edge time refreshed for every in-range channel
        period_nxt = ts_r - last_r[sel];
        last_we    = in_range;
        state_nxt  = mpv_pkg::ST_CHECK;
      end
      mpv_pkg::ST_CHECK: begin
        ok_nxt = period_ok;
        if (period_ok) begin
          div_ctrl.start = 1'b1;
          state_nxt      = mpv_pkg::ST_DIV;
        end else begin
          state_nxt = mpv_pkg::ST_DONE;
        end
      end
      mpv_pkg::ST_DIV: begin
        if (div_stat.done) begin
          held_we   = 1'b1;
          state_nxt = mpv_pkg::ST_DONE;
        end
      end
      mpv_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = ch_r;
          out_volt_nxt  = in_range ? held_r[sel] : '0;
          out_acc_nxt   = ok_r;
          state_nxt     = mpv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mpv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpv_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    ts_r       <= ts_nxt;
    period_r   <= period_nxt;
    ok_r       <= ok_nxt;
    out_ch_r   <= out_ch_nxt;
    out_volt_r <= out_volt_nxt;
    out_acc_r  <= out_acc_nxt;
  end

  // channel state, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_r[i] <= '0;
        held_r[i] <= '0;
      end
    end else begin
      if (last_we) last_r[sel] <= ts_r;
      if (held_we) held_r[sel] <= div_stat.quotient[mpv_pkg::VOLT_W-1:0];
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.out_channel = out_ch_r;
  assign out_res.voltage     = out_volt_r;
  assign out_res.accepted    = out_acc_r;

endmodule

// File: hdl/mpv_cfg.sv
// ----------------------------------------------------------------------------
// mpv_cfg
// register file: channel coefficients and period limit, apb write and read
// ----------------------------------------------------------------------------
module mpv_cfg #(
  parameter int CHANNELS = mpv_pkg::CHANNELS_DEF,
  parameter int CH_IDX_W = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mpv_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mpv_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mpv_pkg::CFG_DATA_W-1:0]  prdata,
  input  logic [CH_IDX_W-1:0]             sel,
  output logic [mpv_pkg::COEFF_W-1:0]     coeff_sel,
  output logic [mpv_pkg::MAXP_W-1:0]      max_period
);

  logic [mpv_pkg::COEFF_W-1:0]    coeff_r [CHANNELS];
  logic [mpv_pkg::MAXP_W-1:0]     max_period_r;
  logic [mpv_pkg::CFG_DATA_W-1:0] prdata_r, prdata_nxt;
  logic [mpv_pkg::REG_IDX_W-1:0]  idx;
  logic                           wr_en;
  logic                           is_coeff;

  assign idx      = paddr[mpv_pkg::CFG_ADDR_W-1:2];
  assign wr_en    = psel && penable && pwrite;
  assign is_coeff = (idx < mpv_pkg::NUM_COEFF_REGS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) coeff_r[i] <= mpv_pkg::COEFF_RESET;
      max_period_r <= mpv_pkg::MAX_PERIOD_RESET;
    end else if (wr_en) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (is_coeff && (32'(idx) == i)) coeff_r[i] <= pwdata[mpv_pkg::COEFF_W-1:0];
      end
      if (idx == mpv_pkg::REG_MAX_PERIOD) max_period_r <= pwdata[mpv_pkg::MAXP_W-1:0];
    end
  end

  // read data captured in the setup cycle, valid through the access cycle
  always_comb begin
    prdata_nxt = prdata_r;
    if (psel && !penable) begin
      prdata_nxt = '0;
      for (int i = 0; i < CHANNELS; i++) begin
        if (is_coeff && (32'(idx) == i)) prdata_nxt = {1'b0, coeff_r[i]};
      end
      if (idx == mpv_pkg::REG_MAX_PERIOD) prdata_nxt = max_period_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prdata_r <= '0;
    end else begin
      prdata_r <= prdata_nxt;
    end
  end

  assign prdata     = prdata_r;
  assign coeff_sel  = coeff_r[sel];
  assign max_period = max_period_r;

endmodule

// File: hdl/mpv_div.sv
// ----------------------------------------------------------------------------
// mpv_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mpv_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mpv_pkg::div_ctrl_t ctrl,
  output mpv_pkg::div_stat_t stat
);

  localparam int QW    = mpv_pkg::COEFF_W;
  localparam int DW    = mpv_pkg::MAXP_W;
  localparam int CNT_W = $clog2(QW);

  logic [QW-1:0]    q_r, q_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      shifted;
  logic [DW+1:0]    diff;

  // partial remainder shifted left with the next dividend bit
  assign shifted = {rem_r, q_r[QW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctrl.start) begin
      q_nxt    = ctrl.dividend;
      rem_nxt  = '0;
      dvs_nxt  = ctrl.divisor;
      cnt_nxt  = CNT_W'(QW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (diff[DW+1]) begin
        rem_nxt = shifted[DW-1:0];
      end else begin
        rem_nxt = diff[DW-1:0];
      end
      q_nxt = {q_r[QW-2:0], ~diff[DW+1]};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.done     = done_r;
  assign stat.quotient = q_r;

endmodule

// File: hdl/mpv_chk.sv
// ----------------------------------------------------------------------------
// mpv_chk
// port-level checks on the period-to-voltage block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpv_chk #(
  parameter int CHANNELS = mpv_pkg::CHANNELS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mpv_pkg::CHAN_W-1:0]     out_channel,
  input logic [mpv_pkg::VOLT_W-1:0]     voltage,
  input logic                           accepted
);

  logic in_xfer;
  logic out_stall;
  logic bad_chan;

  assign in_xfer   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign bad_chan  = out_valid && (32'(out_channel) >= CHANNELS);

  // a stalled result keeps its payload
  `CHK_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_channel) && $stable(voltage) && $stable(accepted), "result changed while stalled")

  // one edge in work at a time
  `CHK_NEXT(a_one_item, clk, rst_n, in_xfer, !in_ready, "edge taken while busy")

  // no result rises before the period, check and load steps of an edge
  `CHK_NEXT(a_min_latency, clk, rst_n, in_xfer, !$rose(out_valid) ##1 !$rose(out_valid), "result too early after transfer")

  // an unknown channel is never accepted and reports no voltage
  `CHK_IMPLY(a_bad_chan, clk, rst_n, bad_chan, !accepted && (voltage == '0), "unknown channel result")

endmodule

bind multichannel_period_to_voltage mpv_chk #(
  .CHANNELS (CHANNELS)
) u_mpv_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_evt.valid),
  .in_ready    (in_evt.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_channel (out_res.out_channel),
  .voltage     (out_res.voltage),
  .accepted    (out_res.accepted)
);
